// ----- src/delta_run_length_encoder_unit_defines.svh -----
// Assertion macros for the delta run-length encoder unit.
// Used by the top level only; it expects clk_i and rst_ni in scope.
`ifndef DELTA_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH
`define DELTA_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define DRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define DRLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define DRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DRLE_ASSERT(lbl, prop, msg)
`define DRLE_ASSERT_IMPL(lbl, ante, cons, msg)
`define DRLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/drle_pkg.sv -----
// Package for the delta run-length encoder unit: item types, code constants.
// No dependencies; used by every module of the block.
package drle_pkg;

  localparam int unsigned SampleW    = 8;
  localparam int unsigned CodeW      = 11;
  localparam int unsigned CodeLenW   = 4;
  localparam int unsigned RunW       = 3;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = 2;

  // Fixed code lengths
  localparam logic [CodeLenW-1:0] LenRaw   = 4'd8;
  localparam logic [CodeLenW-1:0] LenRun   = 4'd5;
  localparam logic [CodeLenW-1:0] LenLarge = 4'd11;
  localparam logic [CodeLenW-1:0] LenEnd   = 4'd2;

  // Prefixes
  localparam logic [1:0] PrefixRun   = 2'b01;
  localparam logic [1:0] PrefixLarge = 2'b10;
  localparam logic [1:0] PrefixEnd   = 2'b11;

  // Small delta class limits and offsets
  localparam logic [SampleW-1:0] Lim0 = 8'd2;
  localparam logic [SampleW-1:0] Lim1 = 8'd6;
  localparam logic [SampleW-1:0] Lim2 = 8'd14;
  localparam logic [SampleW-1:0] Lim3 = 8'd30;
  localparam logic [RunW-1:0]    RunFull = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]    code;
    logic [CodeLenW-1:0] code_length;
    logic                last_of_item;
    logic                end_of_stream;
  } out_item_t;

  typedef struct packed {
    logic [SampleW-1:0] prev;
    logic [RunW-1:0]    run;
    logic               first;
  } enc_state_t;

endpackage

// ----- src/drle_code_gen.sv -----
// Code generator: turns one sample and the encoder state into up to three
// codes and the next state. Pure combinational; depends on drle_pkg.
module drle_code_gen import drle_pkg::*; (
  input  in_item_t                     item_i,
  input  enc_state_t                   state_i,
  output enc_state_t                   state_o,
  output out_item_t [MaxResults-1:0]   res_o,
  output logic [CntW-1:0]              res_cnt_o
);

  logic signed [SampleW:0] delta;
  logic        [SampleW-1:0] mag;
  logic                    neg;
  logic [SampleW-1:0]      idx;
  logic [CodeW-1:0]        small_code;
  logic [CodeLenW-1:0]     small_len;
  logic [CodeW-1:0]        main_code;
  logic [CodeLenW-1:0]     main_len;
  logic                    main_v;
  logic                    run_v;
  logic [RunW-1:0]         run_m1;
  logic [RunW-1:0]         run_next;
  out_item_t [MaxResults-1:0] cand;
  logic      [MaxResults-1:0] cand_v;
  logic [CntW-1:0]         slot;

  // Signed difference and its magnitude
  assign delta = $signed({1'b0, item_i.sample}) - $signed({1'b0, state_i.prev});
  assign neg   = delta[SampleW];
  assign mag   = neg ? SampleW'(-delta) : delta[SampleW-1:0];

  // Small delta: class, offset index and code
  always_comb begin
    idx        = '0;
    small_code = '0;
    small_len  = '0;
    priority if (mag <= Lim0) begin
      idx        = neg ? Lim0 - mag : mag + 8'd1;
      small_code = {9'd0, idx[1:0]};
      small_len  = 4'd6;
    end else if (mag <= Lim1) begin
      idx        = neg ? Lim1 - mag : mag + 8'd1;
      small_code = {6'd0, 2'd1, idx[2:0]};
      small_len  = 4'd7;
    end else if (mag <= Lim2) begin
      idx        = neg ? Lim2 - mag : mag + 8'd1;
      small_code = {5'd0, 2'd2, idx[3:0]};
      small_len  = 4'd8;
    end else begin
      idx        = neg ? Lim3 - mag : mag + 8'd1;
      small_code = {4'd0, 2'd3, idx[4:0]};
      small_len  = 4'd9;
    end
  end

  // Choose the main code and run handling
  always_comb begin
    main_v    = 1'b0;
    main_code = '0;
    main_len  = '0;
    run_v     = 1'b0;
    run_m1    = '0;
    run_next  = state_i.run;
    priority if (state_i.first) begin
      main_v    = 1'b1;
      main_code = {3'd0, item_i.sample};
      main_len  = LenRaw;
      run_next  = '0;
    end else if (delta == '0) begin
      if (state_i.run == RunFull) begin
        main_v    = 1'b1;
        main_code = {6'd0, PrefixRun, RunFull};
        main_len  = LenRun;
        run_next  = '0;
      end else begin
        run_next = state_i.run + 3'd1;
        // Flush the extended run at stream end
        if (item_i.last_sample) begin
          run_v  = 1'b1;
          run_m1 = state_i.run;
        end
      end
    end else begin
      // Send the pending run ahead of the delta code
      run_v    = (state_i.run != '0);
      run_m1   = state_i.run - 3'd1;
      run_next = '0;
      main_v   = 1'b1;
      if (mag <= Lim3) begin
        main_code = small_code;
        main_len  = small_len;
      end else begin
        main_code = {PrefixLarge, neg, mag};
        main_len  = LenLarge;
      end
    end
  end

  // Next state; stream end returns to reset values
  always_comb begin
    if (item_i.last_sample) begin
      state_o = '{prev: '0, run: '0, first: 1'b1};
    end else begin
      state_o = '{prev: item_i.sample, run: run_next, first: 1'b0};
    end
  end

  // Candidates in emission order: run, main, end
  always_comb begin
    cand_v = {item_i.last_sample, main_v, run_v};
    cand[0] = '{code: {6'd0, PrefixRun, run_m1}, code_length: LenRun,
                last_of_item: !main_v && !item_i.last_sample, end_of_stream: 1'b0};
    cand[1] = '{code: main_code, code_length: main_len,
                last_of_item: !item_i.last_sample, end_of_stream: 1'b0};
    cand[2] = '{code: {9'd0, PrefixEnd}, code_length: LenEnd,
                last_of_item: 1'b1, end_of_stream: 1'b1};
  end

  // Pack the valid candidates into consecutive slots
  always_comb begin
    res_o = '0;
    slot  = '0;
    for (int i = 0; i < MaxResults; i++) begin
      if (cand_v[i]) begin
        res_o[slot] = cand[i];
        slot        = slot + 2'd1;
      end
    end
    res_cnt_o = slot;
  end

endmodule

// ----- src/delta_run_length_encoder_unit.sv -----
// Top level of the delta run-length encoder unit: state, result buffer.
// Depends on drle_pkg, drle_code_gen and the assertion macro header.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one sample
//   and its last_sample flag. Output channel out_valid_o / out_stall_i /
//   out_item_o carries one variable-length code per item, MSB first,
//   right aligned in code, with code_length valid bits.
//   An accepted sample is coded in the same cycle; its codes (zero to
//   three) sit in a three-entry result buffer and appear one per cycle,
//   while the output is not stalled, from the next cycle on.
//   A sample is taken whenever the buffer will be empty after the current
//   cycle: one sample per cycle when each gives at most one code and the
//   output does not stall; a sample giving more codes holds the input
//   while the single output port drains the buffer.
//   A stall on the output holds the current code and, once the buffer is
//   not emptying, stalls the input.
//   Reset empties the buffer and starts a new stream: the next sample is
//   sent raw. A sample marked last ends the stream with the end code.
`include "delta_run_length_encoder_unit_defines.svh"

module delta_run_length_encoder_unit import drle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  enc_state_t                 state_q, state_d;
  out_item_t [MaxResults-1:0] buf_q, buf_d;
  out_item_t [MaxResults-1:0] res;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [CntW-1:0]            res_cnt;
  logic                       in_acc;
  logic                       out_pop;

  drle_code_gen u_code_gen (
    .item_i    (in_item_i),
    .state_i   (state_q),
    .state_o   (state_d),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // Handshake: take an item only when the buffer is empty after this cycle
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = buf_q[0];
  assign out_pop     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Load new results or advance the buffer
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      buf_d = res;
      cnt_d = res_cnt;
    end else if (out_pop) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{prev: '0, run: '0, first: 1'b1};
      cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // Assertions
  `DRLE_ASSERT_NEXT(a_last_restarts, in_acc && in_item_i.last_sample, state_q.first && (state_q.run == '0) && (state_q.prev == '0), "stream end did not restore reset state")
  `DRLE_ASSERT_IMPL(a_first_no_run, state_q.first, state_q.run == '0, "pending run while expecting a first sample")
  `DRLE_ASSERT_IMPL(a_eos_is_last, out_valid_o && out_item_o.end_of_stream, out_item_o.last_of_item, "end code not marked last of item")
  `DRLE_ASSERT_IMPL(a_last_at_tail, out_valid_o && out_item_o.last_of_item, cnt_q == 2'd1, "last code of item not at buffer tail")

endmodule

// ----- dv/delta_run_length_encoder_unit_tb.sv -----
// Testbench for delta_run_length_encoder_unit: random and directed sample streams with
// random stalls on both sides, checked code by code against a predictor kept here.
// Depends on drle_pkg and the unit's RTL only.
module delta_run_length_encoder_unit_tb import drle_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned HoldAfter   = 60;
  localparam int unsigned ReportMax   = 10;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } pending_sample_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  pending_sample_t samples_to_send[$];
  out_item_t       expected_codes[$];
  out_item_t       sample_codes[$];

  // Predictor state
  logic [SampleW-1:0] pred_prev = '0;
  logic [RunW-1:0]    pred_run = '0;
  bit                 pred_first = 1'b1;

  int unsigned mismatches = 0;
  int unsigned codes_seen = 0;
  int unsigned cycles = 0;

  delta_run_length_encoder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #4 clk_i = ~clk_i;

  // Append one code to those of the current sample
  function automatic void add_code(logic [CodeW-1:0] c, logic [CodeLenW-1:0] len, logic eos);
    out_item_t r;
    r.code          = c;
    r.code_length   = len;
    r.last_of_item  = 1'b0;
    r.end_of_stream = eos;
    sample_codes.insert(sample_codes.size(), r);
  endfunction

  // Send any pending run of repeats
  function automatic void flush_run();
    if (pred_run != '0) begin
      add_code({PrefixRun, pred_run - 3'd1}, LenRun, 1'b0);
      pred_run = '0;
    end
  endfunction

  // Work out the codes of one accepted sample and queue them
  function automatic void encode_sample(in_item_t it);
    int          d;
    int unsigned mag, cls, off, bl, idx;
    sample_codes.delete();
    if (pred_first) begin
      add_code(CodeW'(it.sample), LenRaw, 1'b0);
      pred_first = 1'b0;
    end else begin
      d = int'(it.sample) - int'(pred_prev);
      if (d == 0) begin
        // the eighth repeat sends a full run at once
        if (pred_run == RunFull) begin
          add_code({PrefixRun, RunFull}, LenRun, 1'b0);
          pred_run = '0;
        end else begin
          pred_run = pred_run + 3'd1;
        end
      end else begin
        flush_run();
        mag = (d < 0) ? -d : d;
        if (mag <= Lim3) begin
          if (mag <= Lim0) begin
            cls = 0; off = Lim0;
          end else if (mag <= Lim1) begin
            cls = 1; off = Lim1;
          end else if (mag <= Lim2) begin
            cls = 2; off = Lim2;
          end else begin
            cls = 3; off = Lim3;
          end
          bl  = cls + 2;
          idx = (d < 0) ? int'(d + int'(off)) : int'(d + 1);
          add_code(CodeW'((cls << bl) | idx), CodeLenW'(4 + bl), 1'b0);
        end else begin
          add_code({PrefixLarge, (d < 0) ? 1'b1 : 1'b0, mag[7:0]}, LenLarge, 1'b0);
        end
      end
    end
    pred_prev = it.sample;
    // close the stream and start afresh
    if (it.last_sample) begin
      flush_run();
      add_code(CodeW'(PrefixEnd), LenEnd, 1'b1);
      pred_prev  = '0;
      pred_run   = '0;
      pred_first = 1'b1;
    end
    if (sample_codes.size() > 0) sample_codes[sample_codes.size()-1].last_of_item = 1'b1;
    foreach (sample_codes[i]) expected_codes.insert(expected_codes.size(), sample_codes[i]);
  endfunction

  function automatic void note_mismatch(string what, out_item_t exp_c, out_item_t got);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("mismatch (%s) at %0t: expected code=%h len=%0d loi=%b eos=%b, got code=%h len=%0d loi=%b eos=%b",
               what, $realtime, exp_c.code, exp_c.code_length, exp_c.last_of_item,
               exp_c.end_of_stream, got.code, got.code_length, got.last_of_item,
               got.end_of_stream);
  endfunction

  task automatic queue_sample(logic [SampleW-1:0] s, bit is_last, int unsigned gap, bit drain);
    pending_sample_t p;
    p.item.sample      = s;
    p.item.last_sample = is_last;
    p.gap              = gap;
    p.drain            = drain;
    samples_to_send.insert(samples_to_send.size(), p);
  endtask

  // Driver: offer queued samples, honouring each item's gap and drain request
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic     nxt_valid;
    in_item_t nxt_item;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_item   <= '0;
      gap_left  = 0;
      gap_armed = 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_item  = in_item;
      if (in_valid && !in_stall) begin
        encode_sample(in_item);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && samples_to_send.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = samples_to_send[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!samples_to_send[0].drain || expected_codes.size() == 0) begin
          nxt_item  = samples_to_send[0].item;
          nxt_valid = 1'b1;
          void'(samples_to_send.pop_front());
          gap_armed = 1'b0;
        end
      end
      in_valid <= nxt_valid;
      in_item  <= nxt_item;
    end
  end

  // Long receiver hold: once enough codes have passed, hold off so the unit backs up
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        hold_stall = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  = 0;
      hold_done  = 1'b0;
      hold_stall <= 1'b0;
    end else begin
      if (!hold_done && codes_seen >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      hold_stall <= (hold_left > 0);
    end
  end

  // Monitor: check each accepted code and draw the receiver's stalls
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_c;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          note_mismatch("unexpected", '0, out_item);
        end else begin
          exp_c = expected_codes.pop_front();
          if (out_item.code !== exp_c.code || out_item.code_length !== exp_c.code_length ||
              out_item.last_of_item !== exp_c.last_of_item ||
              out_item.end_of_stream !== exp_c.end_of_stream)
            note_mismatch("field", exp_c, out_item);
        end
        codes_seen++;
        stall_left = ((codes_seen % 128) >= 96) ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_stall || (stall_left > 0);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int          deltas[10] = '{2, -1, 6, -3, 14, -7, 30, -15, 31, -31};
    int          cur, d, nxt, strm_len, rep_left, kind, cls, n_items, n_streams;
    bit          quiet;
    int unsigned gap;

    // Directed: extremes of the large delta and stream end on a large delta
    queue_sample(8'h00, 1'b0, $urandom_range(0, 3), 1'b0);
    queue_sample(8'hFF, 1'b0, $urandom_range(0, 3), 1'b0);
    queue_sample(8'h00, 1'b1, $urandom_range(0, 3), 1'b0);
    // Directed: every small delta class, both signs, at its edges, then the smallest large deltas
    cur = 100;
    queue_sample(8'(cur), 1'b0, $urandom_range(0, 3), 1'b0);
    foreach (deltas[i]) begin
      cur += deltas[i];
      queue_sample(8'(cur), 1'b0, $urandom_range(0, 3), 1'b0);
    end
    // Directed: a short run before a change
    queue_sample(8'(cur), 1'b0, 0, 1'b0);
    queue_sample(8'(cur), 1'b0, 0, 1'b0);
    cur += 1;
    queue_sample(8'(cur), 1'b0, 0, 1'b0);
    // Directed: a run reaching eight, then one repeat left over at stream end
    repeat (8) queue_sample(8'(cur), 1'b0, 0, 1'b0);
    queue_sample(8'(cur), 1'b1, $urandom_range(0, 3), 1'b0);
    // Directed: first sample marked last
    queue_sample(8'hFF, 1'b1, $urandom_range(0, 3), 1'b0);

    // Random: well-formed streams of repeats, small and large deltas
    n_items   = 0;
    n_streams = 0;
    while (n_items < RandomItems) begin
      strm_len = $urandom_range(1, 24);
      quiet    = ($urandom_range(0, 3) == 0);
      cur      = $urandom_range(0, 255);
      rep_left = 0;
      for (int i = 0; i < strm_len; i++) begin
        if (i > 0) begin
          if (rep_left > 0) begin
            rep_left--;
          end else begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
              rep_left = $urandom_range(5, 18);
            end else if (kind < 6) begin
              // plain repeat
            end else if (kind < 13) begin
              cls = $urandom_range(0, 3);
              d   = $urandom_range(1, (4 << cls) - 2);
              if ($urandom_range(0, 1)) d = -d;
              nxt = cur + d;
              cur = (nxt < 0 || nxt > 255) ? int'($urandom_range(0, 255)) : nxt;
            end else begin
              cur = $urandom_range(0, 255);
            end
          end
        end
        gap = quiet ? 0 : $urandom_range(0, 3);
        // a stray end mark now and then breaks a stream early
        queue_sample(8'(cur), (i == strm_len - 1) || ($urandom_range(0, 39) == 0), gap,
                     (n_streams == 6) && (i == 0));
        n_items++;
      end
      n_streams++;
    end

    // Reset once, then wait for the traffic to drain
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (samples_to_send.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- delta_run_length_encoder_unit.f -----
+incdir+src
src/drle_pkg.sv
src/drle_code_gen.sv
src/delta_run_length_encoder_unit.sv
dv/delta_run_length_encoder_unit_tb.sv
